// ----- rtl/core/sgg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the gait generator.
package sgg_pkg;

    // Joint slots per tick are MAX_SEGMENTS - 1
    localparam int MAX_SEGMENTS    = 16;
    localparam int SINE_TABLE_BITS = 10;

    localparam int SLOTS   = MAX_SEGMENTS - 1;
    localparam int SLOT_W  = $clog2(MAX_SEGMENTS);
    localparam int Q_W     = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << Q_W;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ANGLE   = 3'd0,
        CFG_JOINT_COUNT = 3'd1,
        CFG_PHASE_RATE  = 3'd2,
        CFG_RISE_FACTOR = 3'd3,
        CFG_TURN_SHARE  = 3'd4,
        CFG_LAG_STEP    = 3'd5
    } t_cfg_idx;

    // Sequencer states, one-hot
    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_ADV1  = 16'h0002,
        S_ADV2  = 16'h0004,
        S_PHASE = 16'h0008,
        S_WAMP  = 16'h0010,
        S_BIAS1 = 16'h0020,
        S_BIAS2 = 16'h0040,
        S_DAMP  = 16'h0080,
        S_RAMPA = 16'h0100,
        S_UPDA  = 16'h0200,
        S_RAMPB = 16'h0400,
        S_UPDB  = 16'h0800,
        S_SINE  = 16'h1000,
        S_SMUL  = 16'h2000,
        S_SACC  = 16'h4000,
        S_SOUT  = 16'h8000
    } t_state;

    // Sine sample as sign and magnitude
    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } t_sine;

    typedef logic [14:0] t_rom [0:QUARTER];

    // Unsigned long division by shift and subtract, used only to build the table
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave table from an integer Taylor series in Q.30, rounded to Q1.15
    function automatic t_rom build_rom();
        t_rom            rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned usum;
        longint          sum;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> Q_W;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = div_u64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) <<< 30)) begin
                sum = longint'(1) <<< 30;
            end
            usum   = longint'(sum);
            rom[k] = 15'((usum * 64'd32767 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

// ----- rtl/core/serpentine_gait_generator.sv -----
// Serpenoid gait generator top level: sequencer, state registers and output word.
//
// One input word (forward, turn, time step) produces one output word per joint
// slot, slots 0 to 14, the last flagged by last_joint. A small sequencer runs all
// arithmetic through a single shared 32x16 multiplier: it first advances the wave
// phase and ramps amplitude and bias, then takes each slot through sine lookup,
// multiply, bias add, and round and clamp; the output step waits while the output
// side stalls. The input side is stalled for the whole tick; a finished word waits
// in the output register while the next tick is accepted. Configuration writes
// take effect at once and are meant to be made only between ticks.
module serpentine_gait_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [sgg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                  i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [15:0]           i_forward,
    input  logic signed [15:0]           i_turn,
    input  logic [15:0]                  i_time_step,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [3:0]                   o_joint_slot,
    output logic signed [15:0]           o_target_angle,
    output logic                         o_last_joint
);
    import sgg_pkg::*;

    // Configuration registers
    logic [14:0] r_max_angle;
    logic [3:0]  r_joint_count;
    logic [15:0] r_phase_rate;
    logic [15:0] r_rise;
    logic [15:0] r_share;
    logic [15:0] r_lag_step;

    // Persistent gait state
    logic [31:0]        r_phase;
    logic signed [23:0] r_amp;
    logic signed [23:0] r_bias;

    // Per-tick working registers
    t_state             r_state, n_state;
    logic [14:0]        r_fmag;
    logic               r_fneg;
    logic [14:0]        r_tmag;
    logic               r_tneg;
    logic [15:0]        r_dt;
    logic [22:0]        r_wamp;
    logic signed [23:0] r_wbias;
    logic [24:0]        r_dmag;
    logic               r_dneg;
    logic [SLOT_W-1:0]  r_slot;
    logic [15:0]        r_lag;
    logic signed [41:0] r_acc;

    // Output word
    logic               r_ovalid;
    logic [3:0]         r_oslot;
    logic signed [15:0] r_otarget;
    logic               r_olast;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    t_sine              sine;
    logic [31:0]        angle;

    logic               in_acc;
    logic               out_free;
    logic [14:0]        fwd_mag;
    logic [14:0]        trn_mag;
    logic [31:0]        adv;
    logic [22:0]        bias_mag;
    logic signed [24:0] amp_up, amp_dn;
    logic signed [24:0] bias_up, bias_dn;
    logic [24:0]        step;
    logic signed [41:0] bias_ext;
    logic [41:0]        prod_sel;
    logic signed [41:0] rnd;
    logic signed [18:0] tq;
    logic signed [18:0] lim;
    logic signed [18:0] clamped;
    logic               active;
    logic               last;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Saturated command magnitudes; full-scale negative clips to 32767
    assign fwd_mag = (i_forward == -16'sd32768) ? 15'd32767 :
                     i_forward[15] ? 15'(-i_forward) : i_forward[14:0];
    assign trn_mag = (i_turn == -16'sd32768) ? 15'd32767 :
                     i_turn[15] ? 15'(-i_turn) : i_turn[14:0];

    // Shared multiplier
    sgg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Sine of phase minus this slot's lag
    assign angle = r_phase - {r_lag, 16'd0};

    sgg_sine u_sine (
        .i_clk   (i_clk),
        .i_en    (r_state == S_SINE),
        .i_angle (angle),
        .o_sine  (sine)
    );

    // Operand selection per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ADV1: begin
                mul_a = MUL_A_W'(r_phase_rate);
                mul_b = MUL_B_W'(r_fmag);
            end
            S_ADV2: begin
                mul_a = MUL_A_W'(prod[30:0]);
                mul_b = r_dt;
            end
            S_PHASE: begin
                mul_a = MUL_A_W'(r_max_angle);
                mul_b = MUL_B_W'(r_fmag);
            end
            S_WAMP: begin
                mul_a = MUL_A_W'(r_max_angle);
                mul_b = r_share;
            end
            S_BIAS1: begin
                mul_a = MUL_A_W'(prod[30:0]);
                mul_b = MUL_B_W'(r_tmag);
            end
            S_RAMPA, S_RAMPB: begin
                mul_a = MUL_A_W'(r_dmag);
                mul_b = r_rise;
            end
            S_SMUL: begin
                mul_a = MUL_A_W'(r_amp[22:0]);
                mul_b = MUL_B_W'(sine.mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath helpers
    assign adv      = prod[46:15];
    assign bias_mag = prod[45:23];
    assign amp_up   = 25'(signed'({1'b0, r_wamp})) - 25'(r_amp);
    assign amp_dn   = 25'(r_amp) - 25'(signed'({1'b0, r_wamp}));
    assign bias_up  = 25'(r_wbias) - 25'(r_bias);
    assign bias_dn  = 25'(r_bias) - 25'(r_wbias);
    assign step     = prod[40:16];
    assign bias_ext = {{3{r_bias[23]}}, r_bias, 15'd0};
    assign prod_sel = {1'b0, prod[40:0]} ^ {42{sine.neg}};
    assign rnd      = r_acc + (r_acc[41] ? 42'sd8388607 : 42'sd0);
    assign tq       = rnd[41:23];
    assign lim      = 19'(signed'({1'b0, r_max_angle}));
    assign active   = (32'(r_slot) < 32'(r_joint_count));
    assign last     = (r_slot == SLOT_W'(SLOTS - 1));

    // Round toward zero, clamp, and zero for inactive slots
    always_comb begin
        if (!active) begin
            clamped = '0;
        end else if (tq > lim) begin
            clamped = lim;
        end else if (tq < -lim) begin
            clamped = -lim;
        end else begin
            clamped = tq;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_ADV1;
            S_ADV1:  n_state = S_ADV2;
            S_ADV2:  n_state = S_PHASE;
            S_PHASE: n_state = S_WAMP;
            S_WAMP:  n_state = S_BIAS1;
            S_BIAS1: n_state = S_BIAS2;
            S_BIAS2: n_state = S_DAMP;
            S_DAMP:  n_state = S_RAMPA;
            S_RAMPA: n_state = S_UPDA;
            S_UPDA:  n_state = S_RAMPB;
            S_RAMPB: n_state = S_UPDB;
            S_UPDB:  n_state = S_SINE;
            S_SINE:  n_state = S_SMUL;
            S_SMUL:  n_state = S_SACC;
            S_SACC:  n_state = S_SOUT;
            S_SOUT: begin
                if (out_free) begin
                    n_state = last ? S_IDLE : S_SINE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control, configuration and gait state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ovalid      <= 1'b0;
            r_max_angle   <= '0;
            r_joint_count <= '0;
            r_phase_rate  <= '0;
            r_rise        <= '0;
            r_share       <= '0;
            r_lag_step    <= '0;
            r_phase       <= '0;
            r_amp         <= '0;
            r_bias        <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_ANGLE:   r_max_angle   <= i_cfg_data[14:0];
                    CFG_JOINT_COUNT: r_joint_count <= i_cfg_data[3:0];
                    CFG_PHASE_RATE:  r_phase_rate  <= i_cfg_data;
                    CFG_RISE_FACTOR: r_rise        <= i_cfg_data;
                    CFG_TURN_SHARE:  r_share       <= i_cfg_data;
                    CFG_LAG_STEP:    r_lag_step    <= i_cfg_data;
                    default: ;
                endcase
            end

            // Phase wraps in 32 bits, direction from the forward sign
            if (r_state == S_PHASE) begin
                r_phase <= r_fneg ? (r_phase - adv) : (r_phase + adv);
            end

            // First-order ramps, step rounded toward zero
            if (r_state == S_UPDA) begin
                r_amp <= r_dneg ? 24'(r_amp - 24'(step)) : 24'(r_amp + 24'(step));
            end
            if (r_state == S_UPDB) begin
                r_bias <= r_dneg ? 24'(r_bias - 24'(step)) : 24'(r_bias + 24'(step));
            end

            // Output word register
            if (r_state == S_SOUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fmag <= fwd_mag;
            r_fneg <= i_forward[15];
            r_tmag <= trn_mag;
            r_tneg <= i_turn[15];
            r_dt   <= i_time_step;
        end
        case (r_state)
            S_WAMP: begin
                r_wamp <= prod[29:7];
            end
            S_BIAS2: begin
                r_wbias <= r_tneg ? -24'(signed'({1'b0, bias_mag}))
                                  :  24'(signed'({1'b0, bias_mag}));
            end
            S_DAMP: begin
                r_dneg <= amp_up[24];
                r_dmag <= amp_up[24] ? amp_dn : amp_up;
            end
            S_UPDA: begin
                r_dneg <= bias_up[24];
                r_dmag <= bias_up[24] ? bias_dn : bias_up;
            end
            S_UPDB: begin
                r_slot <= '0;
                r_lag  <= '0;
            end
            S_SINE: begin
                r_lag <= r_lag + r_lag_step;
            end
            S_SACC: begin
                r_acc <= bias_ext + signed'(prod_sel) + 42'(sine.neg);
            end
            S_SOUT: begin
                if (out_free) begin
                    r_oslot   <= 4'(r_slot);
                    r_otarget <= 16'(clamped);
                    r_olast   <= last;
                    r_slot    <= r_slot + SLOT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_ovalid;
    assign o_joint_slot   = r_oslot;
    assign o_target_angle = r_otarget;
    assign o_last_joint   = r_olast;

endmodule

// ----- rtl/core/sgg_mul.sv -----
// Shared unsigned multiplier with a registered product.
module sgg_mul (
    input  logic                        i_clk,
    input  logic [sgg_pkg::MUL_A_W-1:0] i_a,
    input  logic [sgg_pkg::MUL_B_W-1:0] i_b,
    output logic [sgg_pkg::PROD_W-1:0]  o_prod
);
    import sgg_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // One product per cycle, ready the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/sgg_sine.sv -----
// Quarter-wave sine lookup with registered sign and magnitude.
module sgg_sine (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [31:0]   i_angle,
    output sgg_pkg::t_sine o_sine
);
    import sgg_pkg::*;

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [Q_W-1:0]             q;
    logic [Q_W:0]               addr;
    t_sine                      r_sine;

    // Top bits of the angle pick quadrant and table step
    assign idx  = i_angle[31 -: SINE_TABLE_BITS];
    assign quad = idx[SINE_TABLE_BITS-1 -: 2];
    assign q    = idx[Q_W-1:0];
    assign addr = quad[0] ? ((Q_W+1)'(QUARTER) - {1'b0, q}) : {1'b0, q};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine.mag <= SINE_ROM[addr];
            r_sine.neg <= quad[1];
        end
    end

    assign o_sine = r_sine;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the serpentine gait generator: directed and random ticks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sgg_pkg::*;

    typedef longint unsigned t_u64;

    // One joint word as seen on the output channel
    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] angle;
        logic        last;
    } t_joint_word;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_TICKS  = 34;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [15:0]           i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic signed [15:0]    i_forward = '0;
    logic signed [15:0]    i_turn = '0;
    logic [15:0]           i_time_step = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [3:0]            o_joint_slot;
    logic signed [15:0]    o_target_angle;
    logic                  o_last_joint;

    serpentine_gait_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_forward      (i_forward),
        .i_turn         (i_turn),
        .i_time_step    (i_time_step),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_joint_slot   (o_joint_slot),
        .o_target_angle (o_target_angle),
        .o_last_joint   (o_last_joint)
    );

    // Gait model: register copies and wave state
    logic [14:0] max_angle_r;
    logic [3:0]  joint_count_r;
    logic [15:0] phase_rate_r;
    logic [15:0] rise_r;
    logic [15:0] turn_share_r;
    logic [15:0] lag_step_r;
    logic [31:0] wave_ph;
    longint      swing_amp;
    longint      bend_bias;
    int          quarter_sine [0:QUARTER];

    t_joint_word expected_words [$];

    int send_idle_pct = 11;
    int recv_idle_pct = 46;
    int ticks_sent    = 0;
    int words_seen    = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    logic signed [15:0] held_fwd = '0;
    logic signed [15:0] held_trn = '0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** serpentine_gait_generator: FAILED **");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Quarter-wave sine from a Taylor series in Q.30, rounded to Q1.15
    task automatic fill_quarter_sine();
        t_u64   x;
        t_u64   x2;
        t_u64   term;
        longint acc;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (HALF_PI_Q30 * t_u64'(k)) / t_u64'(QUARTER);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / t_u64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > (longint'(1) <<< 30)) begin
                acc = longint'(1) <<< 30;
            end
            quarter_sine[k] = int'((t_u64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
        end
    endtask

    function automatic longint shr_toward_zero(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = mag >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    // Full-scale negative saturates one step in
    function automatic int clip_cmd(logic signed [15:0] c);
        if (c == 16'h8000) begin
            return -32767;
        end
        return int'(c);
    endfunction

    function automatic int wave_sine(logic [31:0] ang);
        int unsigned idx;
        int unsigned quad;
        int unsigned q;
        int          v;
        idx  = ang >> (32 - SINE_TABLE_BITS);
        quad = (idx >> Q_W) & 3;
        q    = idx & (QUARTER - 1);
        v    = quad[0] ? quarter_sine[QUARTER - q] : quarter_sine[q];
        return quad[1] ? -v : v;
    endfunction

    // Advance the wave for one tick and queue the joint words it should give
    task automatic predict_joint_words(logic signed [15:0] fwd_in,
                                       logic signed [15:0] trn_in,
                                       logic [15:0] dt);
        int          fwd;
        int          trn;
        longint      fmag;
        logic [31:0] adv;
        longint      want_amp;
        longint      want_bias;
        longint      acc;
        longint      tgt;
        longint      lim;
        int          active;
        logic [31:0] lag;
        t_joint_word w;
        fwd  = clip_cmd(fwd_in);
        trn  = clip_cmd(trn_in);
        fmag = (fwd < 0) ? -fwd : fwd;
        adv  = 32'((longint'(phase_rate_r) * fmag * longint'(dt)) >> 15);
        wave_ph = (fwd < 0) ? wave_ph - adv : wave_ph + adv;

        want_amp  = (longint'(max_angle_r) * fmag) >>> 7;
        want_bias = shr_toward_zero(longint'(max_angle_r) * longint'(turn_share_r)
                                    * longint'(trn), 23);
        swing_amp = swing_amp + shr_toward_zero((want_amp - swing_amp) * longint'(rise_r), 16);
        bend_bias = bend_bias + shr_toward_zero((want_bias - bend_bias) * longint'(rise_r), 16);

        active = (joint_count_r > SLOTS) ? SLOTS : int'(joint_count_r);
        lim    = longint'(max_angle_r);
        for (int j = 0; j < SLOTS; j++) begin
            tgt = 0;
            if (j < active) begin
                lag = (32'(j) * 32'(lag_step_r)) << 16;
                acc = swing_amp * longint'(wave_sine(wave_ph - lag)) + bend_bias * 32768;
                tgt = shr_toward_zero(acc, 23);
                if (tgt > lim) begin
                    tgt = lim;
                end
                if (tgt < -lim) begin
                    tgt = -lim;
                end
            end
            w.slot  = 4'(j);
            w.angle = 16'(tgt);
            w.last  = (j == SLOTS - 1);
            expected_words.push_back(w);
        end
    endtask

    task automatic flag_mismatch(string what, t_joint_word want, t_joint_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected slot %0d angle %0d last %0b,",
                     $realtime, what, want.slot, $signed(want.angle), want.last);
            $display("    got slot %0d angle %0d last %0b",
                     got.slot, $signed(got.angle), got.last);
        end
    endtask

    // Output checker: every accepted word against the oldest expectation
    always @(posedge i_clk) begin
        t_joint_word want;
        t_joint_word got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_seen++;
            got.slot  = o_joint_slot;
            got.angle = o_target_angle;
            got.last  = o_last_joint;
            if (expected_words.size() == 0) begin
                flag_mismatch("unexpected word", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.slot !== want.slot || got.angle !== want.angle
                    || got.last !== want.last) begin
                    flag_mismatch("word mismatch", want, got);
                end
            end
        end
    end

    // Register write; entered and left at a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_MAX_ANGLE:   max_angle_r   = val[14:0];
            CFG_JOINT_COUNT: joint_count_r = val[3:0];
            CFG_PHASE_RATE:  phase_rate_r  = val;
            CFG_RISE_FACTOR: rise_r        = val;
            CFG_TURN_SHARE:  turn_share_r  = val;
            CFG_LAG_STEP:    lag_step_r    = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all_regs(logic [15:0] max_a, logic [15:0] count, logic [15:0] rate,
                                  logic [15:0] rise, logic [15:0] share, logic [15:0] lag);
        write_reg(CFG_MAX_ANGLE, max_a);
        write_reg(CFG_JOINT_COUNT, count);
        write_reg(CFG_PHASE_RATE, rate);
        write_reg(CFG_RISE_FACTOR, rise);
        write_reg(CFG_TURN_SHARE, share);
        write_reg(CFG_LAG_STEP, lag);
    endtask

    // Present one tick word, hold it until taken; entered and left at a falling edge
    task automatic send_tick(logic signed [15:0] fwd, logic signed [15:0] trn,
                             logic [15:0] dt);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(negedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_forward   <= fwd;
        i_turn      <= trn;
        i_time_step <= dt;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_joint_words(fwd, trn, dt);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every outstanding word, then a short quiet spell
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_reg();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_cmd();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'h8001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(1023));
        endcase
    endfunction

    // Zero registers after reset: every target must be zero
    task automatic test_after_reset();
        send_tick(16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_tick(16'sh8000, 16'sh7FFF, 16'h0001);
        settle();
    endtask

    // Full-scale settings, command extremes and saturation, clamp on large bend
    task automatic test_full_scale();
        write_all_regs(16'h7FFF, 16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1000);
        send_tick(16'sh7FFF, 16'sh0000, 16'd1000);
        send_tick(16'sh8000, 16'sh8000, 16'd1000);
        send_tick(16'sh8001, 16'sh7FFF, 16'hFFFF);
        send_tick(16'sh0000, 16'sh7FFF, 16'h0000);
        send_tick(16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_tick(16'sh4000, 16'shC000, 16'd77);
        settle();
    endtask

    // Joint counts from none to all slots; inactive slots give zero
    task automatic test_joint_counts();
        int counts [5] = '{0, 1, 7, 14, 15};
        write_all_regs(16'd20000, 16'd0, 16'd3000, 16'h8000, 16'd40000, 16'd5000);
        foreach (counts[i]) begin
            write_reg(CFG_JOINT_COUNT, 16'(counts[i]));
            send_tick(16'sh6000, 16'sh2000, 16'd300);
            settle();
        end
    endtask

    // Undecoded indexes are ignored; spare data bits of max angle are dropped
    task automatic test_spare_registers();
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h5A5A);
        write_reg(CFG_MAX_ANGLE, 16'hC123);
        send_tick(16'sh7FFF, 16'sh1234, 16'd500);
        send_tick(16'shA000, 16'shE000, 16'd500);
        settle();
    endtask

    // Zero max angle clamps everything to zero despite carried-over state
    task automatic test_zero_max_angle();
        write_reg(CFG_MAX_ANGLE, 16'h0000);
        send_tick(16'sh7FFF, 16'sh7FFF, 16'd900);
        send_tick(16'sh8000, 16'sh8000, 16'd900);
        settle();
    endtask

    // Random settings, commands held over several ticks so the ramps build up
    task automatic test_random_ticks(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_all_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            if (i == RANDOM_TICKS / 2) begin
                settle();
                write_all_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                               pick_reg());
            end
            if ($urandom_range(99) < 40) begin
                held_fwd = pick_cmd();
            end
            if ($urandom_range(99) < 40) begin
                held_trn = pick_cmd();
            end
            send_tick(held_fwd, held_trn, pick_dt());
        end
        settle();
    endtask

    initial begin
        max_angle_r   = '0;
        joint_count_r = '0;
        phase_rate_r  = '0;
        rise_r        = '0;
        turn_share_r  = '0;
        lag_step_r    = '0;
        wave_ph       = '0;
        swing_amp     = 0;
        bend_bias     = 0;
        fill_quarter_sine();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_after_reset();
        test_full_scale();
        test_joint_counts();
        test_spare_registers();
        test_zero_max_angle();
        test_random_ticks(11, 46);
        test_random_ticks(46, 11);
        test_random_ticks(0, 0);

        $display("Run covered %0d ticks and %0d joint words: register extremes, saturation,",
                 ticks_sent, words_seen);
        $display("joint counts, spare indexes and three idling mixes; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("** serpentine_gait_generator: PASSED **");
        end else begin
            $display("** serpentine_gait_generator: FAILED **");
        end
        $finish;
    end

endmodule
